// ----- rtl/qs_pkg.sv -----
// Shared types and constants for the quicksort sorter.
package qs_pkg;

  // Element and index widths
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 7;   // holds 0..127, enough for a count of 0..64
  localparam int HALF_W      = 6;   // one bound inside a stack entry
  localparam int STACK_DEPTH = 64;
  localparam int STACK_AW    = 6;

  // Input word: one element, last closes the set
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_word_t;

  // Output word: one sorted element
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_word_t;

  // Pending subrange on the range stack
  typedef struct packed {
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } range_t;

endpackage

// ----- rtl/quicksort_sorter_top.sv -----
// Quicksort sorter: loads a set, sorts it in place with one compare unit, streams it out.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): one signed 32-bit element
//   per word; the word with last set closes the set and starts the sort. Up to
//   CAPACITY elements are stored; later ones are dropped and the set is flagged.
//   Output channel (out_valid_o / out_stall_i / out_word_o): the stored elements in
//   ascending order, final_res on the last one, overflow on every word of a set
//   that lost elements.
// Flow:
//   Loading takes one word per cycle. After the closing word the input stalls
//   while the sort runs: each element compare uses the single store read port
//   (address, then registered data), each swap writes both elements in turn,
//   and each partition adds pivot, fix-up and push steps. The set then streams
//   out, each word read from the store (address, then registered data) before
//   it is registered, so words do not come out back to back. The input opens again
//   once the last word sits in the output register.
// Reset returns the sequencer to loading and clears the element count, the stack
// pointer, the overflow flag and the output valid; the memories are not cleared.
// A stalled output word holds; the sequencer simply waits on it.
module quicksort_sorter_top #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qs_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qs_pkg::out_word_t out_word_o
);
  import qs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPW,
    ST_PIVW,
    ST_OUTER,
    ST_LRD,
    ST_LCMP,
    ST_RRD,
    ST_RCMP,
    ST_SWAP,
    ST_SWAP2,
    ST_FIX1,
    ST_FIX2,
    ST_PUSH1,
    ST_PUSH2,
    ST_EMRD,
    ST_EMLD
  } state_e;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         count_q, count_d;
  logic                     dropped_q, dropped_d;
  logic [IDX_W-1:0]         sp_q, sp_d;
  logic [IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]         i_q, i_d, j_q, j_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic signed [DATA_W-1:0] pivot_q, pivot_d;
  logic signed [DATA_W-1:0] vi_q, vi_d, vj_q, vj_d;
  out_word_t                out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  // Memory controls
  logic                     st_we, st_re;
  logic [AW-1:0]            st_waddr, st_raddr;
  logic [DATA_W-1:0]        st_wdata, st_rdata;
  logic                     sk_we, sk_re;
  logic [STACK_AW-1:0]      sk_waddr, sk_raddr;
  range_t                   sk_wdata, sk_rdata;

  // Shared compare unit and partition bookkeeping
  logic                     gt_pivot;
  logic                     in_acc, out_free;
  logic                     left_ok, right_ok, left_big, stack_room;
  range_t                   left_rng, right_rng;
  logic [IDX_W-1:0]         jm1, jp1;

  assign gt_pivot   = $signed(st_rdata) > pivot_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign jm1        = j_q - IDX_W'(1);
  assign jp1        = j_q + IDX_W'(1);
  assign left_ok    = (j_q > lo_q) && (lo_q < jm1);
  assign right_ok   = jp1 < hi_q;
  assign left_big   = (j_q - lo_q) > (hi_q - j_q);
  assign stack_room = sp_q < IDX_W'(STACK_DEPTH);
  assign left_rng   = '{hi: jm1[HALF_W-1:0], lo: lo_q[HALF_W-1:0]};
  assign right_rng  = '{hi: hi_q[HALF_W-1:0], lo: jp1[HALF_W-1:0]};

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    vi_d        = vi_q;
    vj_d        = vj_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = '0;
    st_re       = 1'b0;
    st_raddr    = '0;
    sk_we       = 1'b0;
    sk_waddr    = '0;
    sk_wdata    = '0;
    sk_re       = 1'b0;
    sk_raddr    = '0;

    unique case (state_q)
      // Collect elements until the closing word
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < IDX_W'(CAPACITY)) begin
            st_we    = 1'b1;
            st_waddr = count_q[AW-1:0];
            st_wdata = in_word_i.value;
            count_d  = count_q + IDX_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_word_i.last) begin
            state_d = ST_INIT;
          end
        end
      end
      // Seed the stack with the whole set, or stream at once for fewer than two elements
      ST_INIT: begin
        k_d = '0;
        if (count_q < IDX_W'(2)) begin
          sp_d    = '0;
          state_d = ST_EMRD;
        end else begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = '{hi: HALF_W'(count_q - IDX_W'(1)), lo: '0};
          sp_d     = IDX_W'(1);
          state_d  = ST_POP;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_EMRD;
        end else begin
          sp_d     = sp_q - IDX_W'(1);
          sk_re    = 1'b1;
          sk_raddr = STACK_AW'(sp_q - IDX_W'(1));
          state_d  = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_d = IDX_W'(sk_rdata.lo);
        hi_d = IDX_W'(sk_rdata.hi);
        if (sk_rdata.lo >= sk_rdata.hi) begin
          state_d = ST_POP;
        end else begin
          st_re    = 1'b1;
          st_raddr = AW'(sk_rdata.lo);
          state_d  = ST_PIVW;
        end
      end
      ST_PIVW: begin
        pivot_d = st_rdata;
        i_d     = lo_q;
        j_d     = hi_q + IDX_W'(1);
        state_d = ST_OUTER;
      end
      ST_OUTER: begin
        if (i_q < j_q) begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_LRD;
        end else begin
          state_d = ST_FIX1;
        end
      end
      // Left scan: bound test before the read
      ST_LRD: begin
        if (i_q <= hi_q) begin
          st_re    = 1'b1;
          st_raddr = i_q[AW-1:0];
          state_d  = ST_LCMP;
        end else begin
          j_d     = jm1;
          state_d = ST_RRD;
        end
      end
      ST_LCMP: begin
        if (!gt_pivot) begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_LRD;
        end else begin
          vi_d    = st_rdata;
          j_d     = jm1;
          state_d = ST_RRD;
        end
      end
      // Right scan
      ST_RRD: begin
        if (j_q > lo_q) begin
          st_re    = 1'b1;
          st_raddr = j_q[AW-1:0];
          state_d  = ST_RCMP;
        end else begin
          state_d = ST_SWAP;
        end
      end
      ST_RCMP: begin
        if (gt_pivot) begin
          j_d     = jm1;
          state_d = ST_RRD;
        end else begin
          vj_d    = st_rdata;
          state_d = ST_SWAP;
        end
      end
      // Swap an out-of-place pair, writing slot i and then slot j
      ST_SWAP: begin
        if (i_q < j_q) begin
          st_we    = 1'b1;
          st_waddr = i_q[AW-1:0];
          st_wdata = vj_q;
          state_d  = ST_SWAP2;
        end else begin
          state_d = ST_FIX1;
        end
      end
      ST_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = j_q[AW-1:0];
        st_wdata = vi_q;
        state_d  = ST_OUTER;
      end
      // Pivot into its slot; when j equals lo the second write wins
      ST_FIX1: begin
        st_we    = 1'b1;
        st_waddr = lo_q[AW-1:0];
        st_wdata = vj_q;
        state_d  = ST_FIX2;
      end
      ST_FIX2: begin
        st_we    = 1'b1;
        st_waddr = j_q[AW-1:0];
        st_wdata = pivot_q;
        state_d  = ST_PUSH1;
      end
      // Larger side goes on the stack first
      ST_PUSH1: begin
        if (left_big) begin
          sk_we    = left_ok && stack_room;
          sk_wdata = left_rng;
        end else begin
          sk_we    = right_ok && stack_room;
          sk_wdata = right_rng;
        end
        sk_waddr = sp_q[STACK_AW-1:0];
        if (sk_we) begin
          sp_d = sp_q + IDX_W'(1);
        end
        state_d = ST_PUSH2;
      end
      ST_PUSH2: begin
        if (left_big) begin
          sk_we    = right_ok && stack_room;
          sk_wdata = right_rng;
        end else begin
          sk_we    = left_ok && stack_room;
          sk_wdata = left_rng;
        end
        sk_waddr = sp_q[STACK_AW-1:0];
        if (sk_we) begin
          sp_d = sp_q + IDX_W'(1);
        end
        state_d = ST_POP;
      end
      // Stream the sorted set
      ST_EMRD: begin
        st_re    = 1'b1;
        st_raddr = k_q[AW-1:0];
        state_d  = ST_EMLD;
      end
      ST_EMLD: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = st_rdata;
          out_d.final_res    = (k_q == count_q - IDX_W'(1));
          out_d.overflow     = dropped_q;
          if (k_q == count_q - IDX_W'(1)) begin
            count_d   = '0;
            dropped_d = 1'b0;
            sp_d      = '0;
            state_d   = ST_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_EMRD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    vi_q    <= vi_d;
    vj_q    <= vj_d;
    out_q   <= out_d;
  end

  // Element store
  qs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // Range stack
  qs_ram #(
    .WIDTH(2 * HALF_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .re_i   (sk_re),
    .raddr_i(sk_raddr),
    .rdata_o(sk_rdata)
  );

endmodule

// ----- rtl/qs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
module qs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/qs_checker.sv -----
// Port-level checks for the quicksort sorter, bound to the top level.
module qs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input qs_pkg::in_word_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qs_pkg::out_word_t out_word_o
);

  // A stalled output word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Closing word starts the sort, so the input stalls next cycle
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.last |=> in_stall_o)
    else $error("input open right after the closing word");

  // Mid-set output words only while the input is closed
  a_stall_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.final_res |-> in_stall_o)
    else $error("input open while a set is still streaming");

  // Overflow flag is the same on consecutive words of one set
  a_overflow_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.final_res ##1 out_valid_o
      |-> out_word_o.overflow == $past(out_word_o.overflow))
    else $error("overflow flag changed inside a set");

endmodule

bind quicksort_sorter_top qs_checker u_qs_checker (.*);
